// ----- rtl/lwbc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lwbc_pkg
// Shared types and codes of the write-back block cache.
// ----------------------------------------------------------------------------
package lwbc_pkg;

    localparam int unsigned DISK_W  = 8;
    localparam int unsigned BLOCK_W = 32;
    localparam int unsigned WORD_W  = 64;

    typedef logic [DISK_W-1:0]  t_disk;
    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [WORD_W-1:0]  t_word;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/lwbc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lwbc_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lwbc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/lru_write_back_block_cache.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_write_back_block_cache
// Fully associative write-back block cache keyed by disk and block, with
// least-recently-used replacement and eviction reports for write-back.
// ----------------------------------------------------------------------------
// Every item walks the entry memory one slot per cycle through its single
// read port: a get makes one pass to find the key and the victim, and a put
// on a non-empty cache makes a second pass that rewrites the recency ranks.
// busy stays high until the cycle that shows the result.
// The result is shown for one cycle on o_valid and cannot be held off.
// Slots fill in order and are never freed, so the fill count marks which
// slots are valid and no clearing pass is needed after reset.
module lru_write_back_block_cache #(
    parameter int unsigned CACHE_ENTRIES = 64,
    parameter int unsigned DATA_BITS     = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             i_operation,
    input  wire lwbc_pkg::t_disk  i_disk_id,
    input  wire lwbc_pkg::t_block i_block_id,
    input  wire lwbc_pkg::t_word  i_write_data,
    output logic                  o_valid,
    output logic                  o_hit,
    output lwbc_pkg::t_word       o_read_data,
    output logic                  o_evict_valid,
    output lwbc_pkg::t_disk       o_evict_disk,
    output lwbc_pkg::t_block      o_evict_block,
    output lwbc_pkg::t_word       o_evict_data
);
    import lwbc_pkg::*;

    localparam int unsigned RW = $clog2(CACHE_ENTRIES);
    localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);
    localparam int unsigned EW = DISK_W + BLOCK_W + DATA_BITS + RW;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count;
    logic [RW-1:0]         r_idx;

    logic                  r_op;
    t_disk                 r_disk;
    t_block                r_block;
    logic [DATA_BITS-1:0]  r_wdata;

    logic                  r_found;
    logic [RW-1:0]         r_fidx;
    logic [RW-1:0]         r_frank;
    logic [DATA_BITS-1:0]  r_fdata;

    logic [RW-1:0]         r_vidx;
    logic [RW-1:0]         r_vrank;
    t_disk                 r_vdisk;
    t_block                r_vblock;
    logic [DATA_BITS-1:0]  r_vdata;

    logic                  r_tgt_en;
    logic [RW-1:0]         r_tgt;
    logic                  r_all;
    logic [RW-1:0]         r_limit;
    logic                  r_insert;

    logic                  r_valid;
    logic                  r_hit;
    t_word                 r_rdata;
    logic                  r_evv;
    t_disk                 r_evd;
    t_block                r_evb;
    t_word                 r_eve;

    logic                  ram_we;
    logic [RW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [RW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;

    t_disk                 rd_disk;
    t_block                rd_block;
    logic [DATA_BITS-1:0]  rd_data;
    logic [RW-1:0]         rd_rank;

    logic                  accept;
    logic                  is_full;
    logic                  is_put;
    logic [RW-1:0]         last_idx;
    logic                  key_match;
    logic [EW-1:0]         new_entry;
    logic [RW-1:0]         upd_rank;

    lwbc_ram #(
        .WIDTH (EW),
        .DEPTH (CACHE_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_disk  = ram_rdata[EW-1 -: DISK_W];
    assign rd_block = ram_rdata[EW-DISK_W-1 -: BLOCK_W];
    assign rd_data  = ram_rdata[RW +: DATA_BITS];
    assign rd_rank  = ram_rdata[RW-1:0];

    assign accept    = start && !busy;
    assign is_full   = (r_count == CW'(CACHE_ENTRIES));
    assign is_put    = (r_op == OP_PUT);
    assign last_idx  = RW'(r_count - 1'b1);
    assign key_match = (rd_disk == r_disk) && (rd_block == r_block);
    assign new_entry = {r_disk, r_block, r_wdata, {RW{1'b0}}};
    assign upd_rank  = (r_all || (rd_rank < r_limit)) ? RW'(rd_rank + 1'b1) : rd_rank;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {rd_disk, rd_block, rd_data, upd_rank};
        ram_raddr = RW'(r_idx + 1'b1);
        n_state   = r_state;
        unique case (r_state)
            ST_IDLE: begin
                ram_raddr = '0;
                if (accept) begin
                    n_state = (r_count == '0) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == last_idx) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                ram_raddr = '0;
                if (!is_put) begin
                    n_state = ST_IDLE;
                end else if (r_found || is_full) begin
                    n_state = ST_UPDATE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = RW'(r_count);
                    ram_wdata = new_entry;
                    n_state   = (r_count == '0) ? ST_IDLE : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                ram_we = 1'b1;
                if (r_tgt_en && (r_idx == r_tgt)) begin
                    ram_wdata = new_entry;
                end
                if (r_idx == last_idx) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    if (accept) begin
                        r_op    <= i_operation;
                        r_disk  <= i_disk_id;
                        r_block <= i_block_id;
                        r_wdata <= i_write_data[DATA_BITS-1:0];
                        r_found <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    r_idx <= RW'(r_idx + 1'b1);
                    if (key_match && !r_found) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_idx;
                        r_frank <= rd_rank;
                        r_fdata <= rd_data;
                    end
                    if (rd_rank == last_idx) begin
                        r_vidx   <= r_idx;
                        r_vrank  <= rd_rank;
                        r_vdisk  <= rd_disk;
                        r_vblock <= rd_block;
                        r_vdata  <= rd_data;
                    end
                end
                ST_DECIDE: begin
                    r_idx    <= '0;
                    r_hit    <= r_found;
                    r_rdata  <= (r_found && !is_put) ? t_word'(r_fdata) : '0;
                    r_evv    <= 1'b0;
                    r_evd    <= '0;
                    r_evb    <= '0;
                    r_eve    <= '0;
                    r_insert <= 1'b0;
                    r_tgt_en <= 1'b1;
                    r_all    <= 1'b0;
                    r_tgt    <= r_fidx;
                    r_limit  <= r_frank;
                    if (!is_put) begin
                        r_valid <= 1'b1;
                    end else if (!r_found) begin
                        if (is_full) begin
                            r_evv   <= 1'b1;
                            r_evd   <= r_vdisk;
                            r_evb   <= r_vblock;
                            r_eve   <= t_word'(r_vdata);
                            r_tgt   <= r_vidx;
                            r_limit <= r_vrank;
                        end else begin
                            r_tgt_en <= 1'b0;
                            r_all    <= 1'b1;
                            if (r_count == '0) begin
                                r_count <= CW'(r_count + 1'b1);
                                r_valid <= 1'b1;
                            end else begin
                                r_insert <= 1'b1;
                            end
                        end
                    end
                end
                ST_UPDATE: begin
                    r_idx <= RW'(r_idx + 1'b1);
                    if (r_idx == last_idx) begin
                        r_valid <= 1'b1;
                        if (r_insert) begin
                            r_count <= CW'(r_count + 1'b1);
                        end
                    end
                end
                default: begin
                    r_idx <= '0;
                end
            endcase
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_hit         = r_hit;
    assign o_read_data   = r_rdata;
    assign o_evict_valid = r_evv;
    assign o_evict_disk  = r_evd;
    assign o_evict_block = r_evb;
    assign o_evict_data  = r_eve;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CACHE_ENTRIES))
        else $error("fill count beyond capacity");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evict_valid) |-> (is_full && !o_hit))
        else $error("eviction without a full cache or on a hit");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

endmodule
`default_nettype wire

// ----- bench/lru_write_back_block_cache_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_write_back_block_cache_test
// Self-checking bench for the write-back block cache: a queued driver issues
// get and put requests with random gaps, a shadow cache predicts hit, read
// data and write-back evictions, and a monitor checks every result strobe.
// ----------------------------------------------------------------------------
module lru_write_back_block_cache_test;

    import lwbc_pkg::*;

    localparam int unsigned CACHE_ENTRIES = 64;
    localparam int unsigned DATA_BITS     = 64;
    localparam int unsigned POOL_KEYS     = 128;
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    localparam t_word       DATA_MASK     = {WORD_W{1'b1}} >> (WORD_W - DATA_BITS);

    typedef struct {
        logic   op;
        t_disk  disk;
        t_block block;
        t_word  wdata;
        bit     drain;
    } t_cache_req;

    typedef struct packed {
        logic   hit;
        t_word  read_data;
        logic   evict_valid;
        t_disk  evict_disk;
        t_block evict_block;
        t_word  evict_data;
    } t_cache_resp;

    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   start        = 1'b0;
    logic   i_operation  = OP_GET;
    t_disk  i_disk_id    = '0;
    t_block i_block_id   = '0;
    t_word  i_write_data = '0;
    logic   busy;
    logic   o_valid;
    logic   o_hit;
    t_word  o_read_data;
    logic   o_evict_valid;
    t_disk  o_evict_disk;
    t_block o_evict_block;
    t_word  o_evict_data;

    lru_write_back_block_cache #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .DATA_BITS     (DATA_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_disk_id     (i_disk_id),
        .i_block_id    (i_block_id),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_data   (o_read_data),
        .o_evict_valid (o_evict_valid),
        .o_evict_disk  (o_evict_disk),
        .o_evict_block (o_evict_block),
        .o_evict_data  (o_evict_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the cache contents
    logic       shadow_valid [CACHE_ENTRIES];
    t_disk      shadow_disk  [CACHE_ENTRIES];
    t_block     shadow_block [CACHE_ENTRIES];
    t_word      shadow_data  [CACHE_ENTRIES];
    logic [5:0] shadow_rank  [CACHE_ENTRIES];

    t_cache_req  cache_req_q[$];
    t_cache_resp predicted_resp_q[$];

    t_disk  pool_disk  [POOL_KEYS];
    t_block pool_block [POOL_KEYS];

    int unsigned get_count     = 0;
    int unsigned put_count     = 0;
    int unsigned hit_count     = 0;
    int unsigned evict_count   = 0;
    int unsigned result_count  = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count   = 0;

    function automatic void promote_slot(int slot, int limit);
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (shadow_valid[i] && i != slot && int'(shadow_rank[i]) < limit)
                shadow_rank[i] = shadow_rank[i] + 6'd1;
        end
        shadow_rank[slot] = '0;
    endfunction

    function automatic t_cache_resp cache_model_access(t_cache_req req);
        t_cache_resp resp;
        t_word       data;
        int          hit_slot;
        int          free_slot;
        int          victim;
        logic [5:0]  worst;
        resp      = '0;
        data      = req.wdata & DATA_MASK;
        hit_slot  = -1;
        free_slot = -1;
        victim    = -1;
        worst     = '0;
        if (req.op == OP_PUT) put_count++;
        else get_count++;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (shadow_valid[i]) begin
                if (hit_slot < 0 && shadow_disk[i] == req.disk && shadow_block[i] == req.block)
                    hit_slot = i;
                if (victim < 0 || shadow_rank[i] >= worst) begin
                    victim = i;
                    worst  = shadow_rank[i];
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit_slot >= 0) begin
            hit_count++;
            resp.hit = 1'b1;
            if (req.op == OP_PUT) begin
                shadow_data[hit_slot] = data;
                promote_slot(hit_slot, int'(shadow_rank[hit_slot]));
            end else begin
                resp.read_data = shadow_data[hit_slot];
            end
        end else if (req.op == OP_PUT) begin
            if (free_slot >= 0) begin
                shadow_valid[free_slot] = 1'b1;
                shadow_disk[free_slot]  = req.disk;
                shadow_block[free_slot] = req.block;
                shadow_data[free_slot]  = data;
                promote_slot(free_slot, CACHE_ENTRIES);
            end else begin
                evict_count++;
                resp.evict_valid = 1'b1;
                resp.evict_disk  = shadow_disk[victim];
                resp.evict_block = shadow_block[victim];
                resp.evict_data  = shadow_data[victim];
                shadow_disk[victim]  = req.disk;
                shadow_block[victim] = req.block;
                shadow_data[victim]  = data;
                promote_slot(victim, int'(shadow_rank[victim]));
            end
        end
        return resp;
    endfunction

    function automatic void add_req(logic op, t_disk disk, t_block block, t_word wdata,
                                    bit drain = 1'b0);
        t_cache_req req;
        req.op    = op;
        req.disk  = disk;
        req.block = block;
        req.wdata = wdata;
        req.drain = drain;
        cache_req_q.push_back(req);
    endfunction

    function automatic t_word random_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return {$urandom, $urandom};
    endfunction

    // driver
    t_cache_req  drv_req;
    t_cache_resp drv_resp;
    logic        drv_start_next;
    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            drv_start_next = start;
            if (start && !busy) begin
                drv_resp = cache_model_access(drv_req);
                predicted_resp_q.push_back(drv_resp);
                drv_start_next = 1'b0;
                gap_left = pick_gap();
            end
            if (!drv_start_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cache_req_q.size() > 0 &&
                             (!cache_req_q[0].drain || predicted_resp_q.size() == 0)) begin
                    drv_req = cache_req_q.pop_front();
                    i_operation    <= drv_req.op;
                    i_disk_id      <= drv_req.disk;
                    i_block_id     <= drv_req.block;
                    i_write_data   <= drv_req.wdata;
                    drv_start_next = 1'b1;
                end
            end
            start <= drv_start_next;
        end
    end

    // monitor
    t_cache_resp mon_got;
    t_cache_resp mon_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            mon_got.hit         = o_hit;
            mon_got.read_data   = o_read_data;
            mon_got.evict_valid = o_evict_valid;
            mon_got.evict_disk  = o_evict_disk;
            mon_got.evict_block = o_evict_block;
            mon_got.evict_data  = o_evict_data;
            if (predicted_resp_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result at cycle %0d: hit=%b rd=%h ev=%b %h/%h %h",
                             cycle_count, mon_got.hit, mon_got.read_data, mon_got.evict_valid,
                             mon_got.evict_disk, mon_got.evict_block, mon_got.evict_data);
            end else begin
                mon_want = predicted_resp_q.pop_front();
                if (mon_got !== mon_want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch on result %0d at cycle %0d", result_count,
                                 cycle_count);
                        $display("  expected hit=%b rd=%h ev=%b %h/%h %h", mon_want.hit,
                                 mon_want.read_data, mon_want.evict_valid, mon_want.evict_disk,
                                 mon_want.evict_block, mon_want.evict_data);
                        $display("  actual   hit=%b rd=%h ev=%b %h/%h %h", mon_got.hit,
                                 mon_got.read_data, mon_got.evict_valid, mon_got.evict_disk,
                                 mon_got.evict_block, mon_got.evict_data);
                    end
                end
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     predicted_resp_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned pool_size;
        int unsigned put_pct;
        int unsigned idx;
        t_disk       disk;
        t_block      block;
        logic        op;

        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_disk[i]  = '0;
            shadow_block[i] = '0;
            shadow_data[i]  = '0;
            shadow_rank[i]  = '0;
        end
        for (int i = 0; i < POOL_KEYS; i++) begin
            pool_disk[i]  = t_disk'($urandom);
            pool_block[i] = (i % 3 == 0) ? t_block'($urandom_range(0, 15)) : t_block'($urandom);
        end
        pool_disk[0]  = '0;
        pool_block[0] = '0;
        pool_disk[1]  = '1;
        pool_block[1] = '1;

        // directed: extreme keys, hits, misses, overwrite
        add_req(OP_GET, 8'h00, 32'h0000_0000, 64'h0);
        add_req(OP_PUT, 8'h00, 32'h0000_0000, 64'h0);
        add_req(OP_PUT, 8'hff, 32'hffff_ffff, '1);
        add_req(OP_GET, 8'h00, 32'h0000_0000, '1);
        add_req(OP_GET, 8'hff, 32'hffff_ffff, 64'h0);
        add_req(OP_GET, 8'hff, 32'h0000_0000, 64'h0);
        add_req(OP_GET, 8'h00, 32'hffff_ffff, 64'h0);
        add_req(OP_PUT, 8'h00, 32'h0000_0000, 64'ha5a5_a5a5_a5a5_a5a5);
        add_req(OP_GET, 8'h00, 32'h0000_0000, 64'h0);
        add_req(OP_PUT, 8'h01, 32'h8000_0000, 64'h8000_0000_0000_0001);
        add_req(OP_PUT, 8'h80, 32'h0000_0001, 64'h0123_4567_89ab_cdef);
        add_req(OP_GET, 8'h80, 32'h0000_0001, 64'h0);
        add_req(OP_PUT, 8'hff, 32'hffff_ffff, 64'h5a5a_5a5a_5a5a_5a5a);
        add_req(OP_GET, 8'h01, 32'h8000_0000, 64'h0);

        // fill to capacity, a get on the oldest entry must not save it
        for (int i = 0; i < CACHE_ENTRIES - 4; i++)
            add_req(OP_PUT, t_disk'($urandom), t_block'($urandom), random_word());
        add_req(OP_GET, 8'h00, 32'h0000_0000, 64'h0);
        for (int i = 0; i < 4; i++)
            add_req(OP_PUT, t_disk'($urandom), t_block'($urandom), random_word());
        add_req(OP_GET, 8'h00, 32'h0000_0000, 64'h0);
        add_req(OP_GET, 8'hff, 32'hffff_ffff, 64'h0);
        add_req(OP_PUT, 8'h00, 32'h0000_0000, '1);

        // random: key pools smaller and larger than the capacity, some noise keys
        for (int seg = 0; seg < 13; seg++) begin
            case (seg % 4)
                0: pool_size = 24;
                1: pool_size = 64;
                2: pool_size = 72;
                default: pool_size = 110;
            endcase
            put_pct = (seg % 3 == 1) ? 30 : 60;
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 99) < 8) begin
                    disk  = t_disk'($urandom);
                    block = t_block'($urandom);
                end else begin
                    idx   = $urandom_range(0, pool_size - 1);
                    disk  = pool_disk[idx];
                    block = pool_block[idx];
                end
                op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
                add_req(op, disk, block, random_word(), (seg == 6 && k == 0));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cache_req_q.size() != 0 || start || predicted_resp_q.size() != 0)
            @(posedge i_clk);
        repeat (2 * CACHE_ENTRIES + 20) @(posedge i_clk);

        $display("%0d requests (%0d gets, %0d puts), %0d hits, %0d write-back evictions",
                 get_count + put_count, get_count, put_count, hit_count, evict_count);
        $display("%0d results checked, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0 && predicted_resp_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lwbc_pkg.sv
rtl/lwbc_ram.sv
rtl/lru_write_back_block_cache.sv
bench/lru_write_back_block_cache_test.sv
